>>> rtl/core/stg_pkg.sv
package stg_pkg;

  localparam int TAPS_DEF   = 8;

  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 15;
  localparam int AMP_W      = 15;
  localparam int COEF_W     = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // shared multiplier operand widths
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 20;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  // low slice of the accumulator used in the first scaling pass
  localparam int LO_W       = 19;
  // the scaled value is divided by 2^31
  localparam int OUT_SHIFT  = 31;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_OUTER = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_2ND   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_3RD   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_CTR   = 3'd5;

  localparam logic [STEP_W-1:0] RST_PHASE_STEP = 15'd492;
  localparam logic [AMP_W-1:0]  RST_AMPLITUDE  = 15'd500;
  localparam logic [COEF_W-1:0] RST_COEF_OUTER = 16'd655;
  localparam logic [COEF_W-1:0] RST_COEF_2ND   = 16'd3277;
  localparam logic [COEF_W-1:0] RST_COEF_3RD   = 16'd7864;
  localparam logic [COEF_W-1:0] RST_COEF_CTR   = 16'd20972;

  typedef struct packed {
    logic [STEP_W-1:0] phase_step;
    logic [AMP_W-1:0]  amplitude;
    logic [COEF_W-1:0] coef_outer;
    logic [COEF_W-1:0] coef_second;
    logic [COEF_W-1:0] coef_third;
    logic [COEF_W-1:0] coef_center;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_SAT
  } state_t;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic scale_lo;
    logic scale_hi;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic pos_adv;
    logic load_held;
  } seq_stat_t;

endpackage

>>> rtl/core/stg_cfg_regs.sv
module stg_cfg_regs
  import stg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step  <= RST_PHASE_STEP;
      cfg_r.amplitude   <= RST_AMPLITUDE;
      cfg_r.coef_outer  <= RST_COEF_OUTER;
      cfg_r.coef_second <= RST_COEF_2ND;
      cfg_r.coef_third  <= RST_COEF_3RD;
      cfg_r.coef_center <= RST_COEF_CTR;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PHASE_STEP: cfg_r.phase_step  <= cfg_wdata[STEP_W-1:0];
        REG_AMPLITUDE:  cfg_r.amplitude   <= cfg_wdata[AMP_W-1:0];
        REG_COEF_OUTER: cfg_r.coef_outer  <= cfg_wdata[COEF_W-1:0];
        REG_COEF_2ND:   cfg_r.coef_second <= cfg_wdata[COEF_W-1:0];
        REG_COEF_3RD:   cfg_r.coef_third  <= cfg_wdata[COEF_W-1:0];
        REG_COEF_CTR:   cfg_r.coef_center <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/stg_ctrl.sv
module stg_ctrl
  import stg_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output mac_ctl_t                 mac_ctl,
  output seq_stat_t                stat,
  output logic [$clog2(TAPS)-1:0]  tap_cnt
);

  localparam int CNT_W = $clog2(TAPS);
  localparam logic [CNT_W-1:0] LAST_TAP = CNT_W'(TAPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_tap;

  assign last_tap = (cnt_r == LAST_TAP);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_TAP;
      ST_TAP:      if (last_tap) state_nxt = ST_SCALE_LO;
      ST_SCALE_LO: state_nxt = ST_SCALE_HI;
      ST_SCALE_HI: state_nxt = ST_SAT;
      ST_SAT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    if (state_r == ST_TAP && !last_tap) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    mac_ctl = '0;
    stat    = '0;
    case (state_r)
      ST_IDLE: begin
        mac_ctl.acc_clr = start;
      end
      ST_TAP: begin
        mac_ctl.acc_en = 1'b1;
        stat.pos_adv   = last_tap;
        stat.busy      = 1'b1;
      end
      ST_SCALE_LO: begin
        mac_ctl.scale_lo = 1'b1;
        stat.busy        = 1'b1;
      end
      ST_SCALE_HI: begin
        mac_ctl.scale_hi = 1'b1;
        stat.busy        = 1'b1;
      end
      ST_SAT: begin
        stat.load_held = 1'b1;
        stat.busy      = 1'b1;
      end
      default: begin
        stat.busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign tap_cnt = cnt_r;

endmodule

>>> rtl/core/stg_mac.sv
module stg_mac
  import stg_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                       clk,
  input  mac_ctl_t                   mac_ctl,
  input  logic        [COEF_W-1:0]   coef,
  input  logic signed [SAMPLE_W-1:0] tap_sample,
  input  logic        [AMP_W-1:0]    amplitude,
  output logic        [SAMPLE_W-1:0] sample
);

  // each tap product fits 33 bits signed, plus growth over the taps
  localparam int ACC_W = 33 + $clog2(TAPS);
  localparam int HI_W  = ACC_W - LO_W;
  localparam int V_W   = ACC_W + AMP_W + 1;
  localparam int MAG_W = V_W - OUT_SHIFT;

  logic signed [ACC_W-1:0]   acc_r;
  logic signed [V_W-1:0]     v_r;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [V_W-1:0]     prod_ext;
  logic        [V_W-1:0]     abs_v;
  logic        [MAG_W-1:0]   mag;
  logic                      upper_set;
  logic        [SAMPLE_W-1:0] neg_mag;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = {{(MUL_A_W-COEF_W){1'b0}}, coef};
    mul_b = {{(MUL_B_W-SAMPLE_W){tap_sample[SAMPLE_W-1]}}, tap_sample};
    if (mac_ctl.scale_lo) begin
      mul_a = {{(MUL_A_W-AMP_W){1'b0}}, amplitude};
      mul_b = {{(MUL_B_W-LO_W){1'b0}}, acc_r[LO_W-1:0]};
    end else if (mac_ctl.scale_hi) begin
      mul_a = {{(MUL_A_W-AMP_W){1'b0}}, amplitude};
      mul_b = {{(MUL_B_W-HI_W){acc_r[ACC_W-1]}}, acc_r[ACC_W-1:LO_W]};
    end
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(V_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (mac_ctl.acc_clr) begin
      acc_r <= '0;
    end else if (mac_ctl.acc_en) begin
      acc_r <= acc_r + prod_ext[ACC_W-1:0];
    end
    if (mac_ctl.scale_lo) begin
      v_r <= prod_ext;
    end else if (mac_ctl.scale_hi) begin
      v_r <= v_r + (prod_ext <<< LO_W);
    end
  end

  // truncate toward zero on the magnitude, then saturate to 16 bits
  assign abs_v     = v_r[V_W-1] ? (~v_r + 1'b1) : v_r;
  assign mag       = abs_v[V_W-1:OUT_SHIFT];
  assign upper_set = |mag[MAG_W-1:SAMPLE_W];
  assign neg_mag   = ~mag[SAMPLE_W-1:0] + 1'b1;

  always_comb begin
    if (v_r[V_W-1]) begin
      if (upper_set || (mag[SAMPLE_W-1] && |mag[SAMPLE_W-2:0])) begin
        sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        sample = neg_mag;
      end
    end else begin
      if (upper_set || mag[SAMPLE_W-1]) begin
        sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        sample = mag[SAMPLE_W-1:0];
      end
    end
  end

endmodule

>>> rtl/core/sawtooth_fir8_tone_generator_top.sv
// Sawtooth tone source with a symmetric FIR low-pass, feeding a codec transmit slot.
//
// in_*  : one transfer per transmit slot; in_tdata[0] is tx_ready. A transfer with
//         tx_ready low is taken and does nothing.
// out_* : one transfer of the held 16-bit sample per slot with tx_ready high,
//         registered and shown the cycle after the input transfer.
// cfg_* : write enable, register index and data; write only while the block is idle.
//
// Every second sample slot refreshes the held sample: the phase advances, enters the
// delay line and the FIR runs through one shared multiplier, one tap a cycle, then
// amplitude scaling on the low and high accumulator slices and a saturation step.
// Such a slot keeps in_tready low while the sequencer works through these steps; any
// other slot leaves it idle. The shared multiplier and accumulator cause the wait.
// A stalled receiver holds out_tvalid and out_tdata, and in_tready stays low until
// the waiting sample has been taken or is taken in the same cycle.
// After reset the delay line, phase and held sample are zero and the registers hold
// their default values; the block is ready in the first cycle after reset.
module sawtooth_fir8_tone_generator_top
  import stg_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] tx_ready, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] out_sample
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TAPS);
  localparam logic [IDX_W:0]   TAPS_X   = (IDX_W+1)'(TAPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

  cfg_t      cfg;
  mac_ctl_t  mac_ctl;
  seq_stat_t stat;

  logic [IDX_W-1:0]    tap_cnt;
  logic [SAMPLE_W-1:0] dly_r [TAPS];
  logic [IDX_W-1:0]    pos_r;
  logic [SAMPLE_W-1:0] phase_r;
  logic [SAMPLE_W-1:0] held_r;
  logic                parity_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;

  logic                take, update;
  logic [SAMPLE_W-1:0] phase_nxt;
  logic [IDX_W:0]      rd_sum;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    mirror, fold;
  logic [COEF_W-1:0]   coef;
  logic [SAMPLE_W-1:0] new_sample;

  stg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_tready = !stat.busy && (!out_valid_r || out_tready);
  assign take      = in_tvalid && in_tready && in_tdata[0];
  assign update    = take && parity_r;
  assign phase_nxt = phase_r + {1'b0, cfg.phase_step};

  stg_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (update),
    .mac_ctl (mac_ctl),
    .stat    (stat),
    .tap_cnt (tap_cnt)
  );

  // ring address of the current tap
  always_comb begin
    rd_sum = {1'b0, pos_r} + {1'b0, tap_cnt};
    if (rd_sum >= TAPS_X) begin
      rd_sum = rd_sum - TAPS_X;
    end
    rd_idx = rd_sum[IDX_W-1:0];
  end

  // symmetric weights: fold the tap onto the nearer end
  always_comb begin
    mirror = LAST_IDX - tap_cnt;
    fold   = (tap_cnt < mirror) ? tap_cnt : mirror;
    if (int'(fold) == 0) begin
      coef = cfg.coef_outer;
    end else if (int'(fold) == 1) begin
      coef = cfg.coef_second;
    end else if (int'(fold) == 2) begin
      coef = cfg.coef_third;
    end else begin
      coef = cfg.coef_center;
    end
  end

  stg_mac #(.TAPS(TAPS)) u_mac (
    .clk        (clk),
    .mac_ctl    (mac_ctl),
    .coef       (coef),
    .tap_sample (dly_r[rd_idx]),
    .amplitude  (cfg.amplitude),
    .sample     (new_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        dly_r[i] <= '0;
      end
      pos_r       <= '0;
      phase_r     <= '0;
      held_r      <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        parity_r    <= ~parity_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (update) begin
        phase_r      <= phase_nxt;
        dly_r[pos_r] <= phase_nxt;
      end
      if (stat.pos_adv) begin
        pos_r <= (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
      end
      if (stat.load_held) begin
        held_r <= new_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= held_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
